[hw/rtl/ttae_pkg.sv]
// Shared types, constants and helper functions for the envelope unit.
package ttae_pkg;

  // Sample and field geometry
  localparam int unsigned SAMPLE_BITS = 24;
  localparam int unsigned PEAK_BITS   = 23;
  localparam int unsigned LEVEL_BITS  = 25;
  localparam int unsigned COEFF_BITS  = 24;
  localparam int unsigned RUN_BITS    = 16;
  localparam int unsigned HOLD_BITS   = 20;
  localparam int unsigned CFG_IDX_BITS  = 3;
  localparam int unsigned CFG_DATA_BITS = 25;

  // Fixed levels
  localparam logic [LEVEL_BITS-1:0] FULL_SCALE   = 25'd16777216;
  localparam logic [LEVEL_BITS-1:0] ACTIVE_LEVEL = 25'd167772;
  localparam logic [PEAK_BITS-1:0]  PEAK_MAX     = 23'd8388607;
  localparam logic [RUN_BITS-1:0]   RUN_MAX      = 16'hFFFF;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLD  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_RISE_COEFF = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_FALL_COEFF = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_ATTACK     = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_RELEASE    = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_SUSTAIN    = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_HYST_ON    = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_HYST_OFF   = 3'd7;

  // Envelope phase
  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_ATTACK  = 2'd1,
    PH_SUSTAIN = 2'd2,
    PH_RELEASE = 2'd3
  } phase_e;

  // Input word: one stereo sample pair
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic [LEVEL_BITS-1:0] envelope_level;
    logic [1:0]            envelope_phase;
    logic                  gate_open;
    logic [PEAK_BITS-1:0]  follower_level;
    logic [PEAK_BITS-1:0]  peak_level;
    logic                  effect_active;
  } out_word_t;

  // Saturated magnitude of one two's complement sample
  function automatic logic [PEAK_BITS-1:0] magnitude(input logic [SAMPLE_BITS-1:0] v);
    logic [SAMPLE_BITS:0] m;
    m = v[SAMPLE_BITS-1] ? ({1'b1, {SAMPLE_BITS{1'b0}}} - {1'b0, v}) : {1'b0, v};
    if (m > {{(SAMPLE_BITS+1-PEAK_BITS){1'b0}}, PEAK_MAX}) begin
      return PEAK_MAX;
    end
    return m[PEAK_BITS-1:0];
  endfunction

endpackage

[hw/rtl/threshold_triggered_asr_envelope_unit.sv]
// Top level: peak detect, follower, gate hysteresis and ASR envelope.
// Path: the peak of an accepted input word is registered at input; the follower, gate and
//   envelope then update into the result register. Throughput: one word per cycle
//   unless stalled; the follower multiply-add feedback loop sets the clock.
// Reset: all state and configuration registers return to their defaults
//   asynchronously; no clearing pass is needed.
module threshold_triggered_asr_envelope_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  ttae_pkg::in_word_t                  in_word_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output ttae_pkg::out_word_t                 out_word_o,
  input  logic                                cfg_we_i,
  input  logic [ttae_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  logic [ttae_pkg::CFG_DATA_BITS-1:0]  cfg_data_i
);
  import ttae_pkg::*;

  // Configuration registers
  logic [PEAK_BITS-1:0]  thresh_q;
  logic [COEFF_BITS-1:0] rise_q, fall_q;
  logic [LEVEL_BITS-1:0] attack_q, release_q;
  logic [HOLD_BITS-1:0]  sustain_q;
  logic [RUN_BITS-1:0]   on_cnt_q, off_cnt_q;

  // Pipeline registers
  logic                 s1_valid_q;
  logic [PEAK_BITS-1:0] s1_peak_q;
  logic                 out_valid_q;
  out_word_t            out_word_q, out_word_d;

  // Block state
  phase_e                phase_q, phase_d;
  logic [LEVEL_BITS-1:0] level_q, level_d;
  logic [HOLD_BITS-1:0]  hold_q, hold_d;
  logic                  gate_q, gate_d;
  logic [RUN_BITS-1:0]   loud_q, loud_d, quiet_q, quiet_d;
  logic [PEAK_BITS-1:0]  follow_q, follow_d;

  logic adv;
  logic in_take;

  // Handshake control
  assign adv        = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !adv;
  assign in_take    = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // Write configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q  <= 23'd265271;
      rise_q    <= 24'd16707455;
      fall_q    <= 24'd16770227;
      attack_q  <= 25'd3495;
      release_q <= 25'd1748;
      sustain_q <= 20'd24000;
      on_cnt_q  <= 16'd64;
      off_cnt_q <= 16'd64;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_THRESHOLD:  thresh_q  <= cfg_data_i[PEAK_BITS-1:0];
        REG_RISE_COEFF: rise_q    <= cfg_data_i[COEFF_BITS-1:0];
        REG_FALL_COEFF: fall_q    <= cfg_data_i[COEFF_BITS-1:0];
        REG_ATTACK:     attack_q  <= cfg_data_i[LEVEL_BITS-1:0];
        REG_RELEASE:    release_q <= cfg_data_i[LEVEL_BITS-1:0];
        REG_SUSTAIN:    sustain_q <= cfg_data_i[HOLD_BITS-1:0];
        REG_HYST_ON:    on_cnt_q  <= cfg_data_i[RUN_BITS-1:0];
        REG_HYST_OFF:   off_cnt_q <= cfg_data_i[RUN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Capture the peak magnitude of the incoming word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  logic [PEAK_BITS-1:0] mag_l, mag_r;
  assign mag_l = magnitude(in_word_i.left_sample);
  assign mag_r = magnitude(in_word_i.right_sample);

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_peak_q <= (mag_l > mag_r) ? mag_l : mag_r;
    end
  end

  // Follower: peak*2^24 + c*(f - peak), rounded, one signed multiply
  logic [COEFF_BITS-1:0]      coeff;
  logic signed [PEAK_BITS:0]  diff;
  logic signed [48:0]         prod;
  logic signed [48:0]         acc;
  logic [23:0]                f_new;

  always_comb begin
    coeff = (s1_peak_q > follow_q) ? rise_q : fall_q;
    diff  = $signed({1'b0, follow_q}) - $signed({1'b0, s1_peak_q});
    prod  = $signed({1'b0, coeff}) * diff;
    acc   = $signed({2'b00, s1_peak_q, 24'd0}) + prod + 49'sd8388608;
    f_new = acc[47:24];
    follow_d = (f_new > {1'b0, PEAK_MAX}) ? PEAK_MAX : f_new[PEAK_BITS-1:0];
  end

  // Hysteresis counters and gate
  logic loud;
  always_comb begin
    loud    = s1_peak_q > thresh_q;
    loud_d  = loud_q;
    quiet_d = quiet_q;
    gate_d  = gate_q;
    if (loud) begin
      loud_d  = (loud_q == RUN_MAX) ? loud_q : loud_q + 16'd1;
      quiet_d = '0;
      if (!gate_q && loud_d >= on_cnt_q) begin
        gate_d = 1'b1;
      end
    end else begin
      quiet_d = (quiet_q == RUN_MAX) ? quiet_q : quiet_q + 16'd1;
      loud_d  = '0;
      if (gate_q && quiet_d >= off_cnt_q) begin
        gate_d = 1'b0;
      end
    end
  end

  // Envelope step arithmetic
  logic [LEVEL_BITS-1:0] atk_s, rel_s;
  logic [LEVEL_BITS:0]   atk_sum;
  logic                  atk_full, rel_floor, hold_end;

  assign atk_s     = (attack_q == '0) ? 25'd1 : attack_q;
  assign rel_s     = (release_q == '0) ? 25'd1 : release_q;
  assign atk_sum   = {1'b0, level_q} + {1'b0, atk_s};
  assign atk_full  = atk_sum >= {1'b0, FULL_SCALE};
  assign rel_floor = rel_s >= level_q;
  assign hold_end  = hold_q <= 20'd1;

  // Envelope next phase
  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      PH_IDLE:    if (gate_d) phase_d = PH_ATTACK;
      PH_ATTACK:  if (atk_full) phase_d = PH_SUSTAIN;
      PH_SUSTAIN: if (hold_end) phase_d = PH_RELEASE;
      PH_RELEASE: begin
        if (gate_d) begin
          phase_d = PH_ATTACK;
        end else if (rel_floor) begin
          phase_d = PH_IDLE;
        end
      end
      default:    phase_d = PH_IDLE;
    endcase
  end

  // Envelope level and sustain countdown
  always_comb begin
    level_d = level_q;
    hold_d  = hold_q;
    case (phase_q)
      PH_ATTACK: begin
        if (atk_full) begin
          level_d = FULL_SCALE;
          hold_d  = sustain_q;
        end else begin
          level_d = atk_sum[LEVEL_BITS-1:0];
        end
      end
      PH_SUSTAIN: begin
        if (hold_end) begin
          hold_d = '0;
        end else if (gate_d) begin
          hold_d = sustain_q;
        end else begin
          hold_d = hold_q - 20'd1;
        end
      end
      PH_RELEASE: level_d = rel_floor ? '0 : level_q - rel_s;
      default: ;
    endcase
  end

  // Assemble the result word
  always_comb begin
    out_word_d.envelope_level = level_d;
    out_word_d.envelope_phase = phase_d;
    out_word_d.gate_open      = gate_d;
    out_word_d.follower_level = follow_d;
    out_word_d.peak_level     = s1_peak_q;
    out_word_d.effect_active  = level_d > ACTIVE_LEVEL;
  end

  // Advance state on each processed word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      level_q  <= '0;
      hold_q   <= '0;
      gate_q   <= 1'b0;
      loud_q   <= '0;
      quiet_q  <= '0;
      follow_q <= '0;
    end else if (adv) begin
      phase_q  <= phase_d;
      level_q  <= level_d;
      hold_q   <= hold_d;
      gate_q   <= gate_d;
      loud_q   <= loud_d;
      quiet_q  <= quiet_d;
      follow_q <= follow_d;
    end
  end

  // Result register: load on advance, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_word_q <= out_word_d;
    end
  end

  // Sustain only ever runs at full scale
  a_sustain_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_SUSTAIN) |-> (level_q == FULL_SCALE))
    else $error("sustain phase below full scale");

  // Idle is only entered with the envelope floored
  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IDLE) |-> (level_q == '0))
    else $error("idle phase with nonzero level");

  // Loud and quiet runs are never both counting
  a_runs_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !((loud_q != '0) && (quiet_q != '0)))
    else $error("loud and quiet runs both nonzero");

  // A processed word always lands in the result register
  a_adv_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_valid_q)
    else $error("processed word lost");

endmodule
